@@ hdl/cbc_pkg.sv @@
// Shared types and constants of the cartridge bank controller.
// Used by the access decoder and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package cbc_pkg;

	localparam int RAM_BANK_BYTES = 8192;
	localparam int RAM_OFS_W      = 13;
	localparam int ROM_OFS_W      = 14;
	localparam int ROM_BANK_W     = 9;
	localparam int ROM_ADDR_W     = 23;
	localparam int CLOCK_REGS     = 5;

	// mapper kinds
	localparam logic [1:0] MAP_ROM  = 2'd0;
	localparam logic [1:0] MAP_MBC1 = 2'd1;
	localparam logic [1:0] MAP_MBC3 = 2'd2;
	localparam logic [1:0] MAP_MBC5 = 2'd3;

	// configuration register indexes
	localparam logic [1:0] REG_MAPPER   = 2'd0;
	localparam logic [1:0] REG_CLOCK    = 2'd1;
	localparam logic [1:0] REG_ROM_SIZE = 2'd2;
	localparam logic [1:0] REG_RAM_SIZE = 2'd3;

	// result targets
	localparam logic [1:0] TGT_OPEN  = 2'd0;
	localparam logic [1:0] TGT_ROM   = 2'd1;
	localparam logic [1:0] TGT_RAM   = 2'd2;
	localparam logic [1:0] TGT_CLOCK = 2'd3;

	localparam logic [7:0] OPEN_BUS       = 8'hFF;
	localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;
	localparam logic [7:0] CLOCK_SEL_BASE = 8'h08;
	localparam logic [7:0] CLOCK_SEL_LAST = 8'h0C;
	localparam logic [7:0] RAM_SEL_LAST   = 8'h03;
	localparam logic [3:0] ROM_CODE_MAX   = 4'd8;

	typedef struct packed {
		logic [1:0] mapper_kind;
		logic       clock_present;
		logic [3:0] rom_size_code;
		logic [2:0] ram_code;
	} cfg_t;

	typedef struct packed {
		logic [1:0]            target;
		logic [ROM_ADDR_W-1:0] phys_addr;
		logic [7:0]            rdata;
		logic                  ram_re;
		logic                  ram_we;
	} dec_t;

endpackage

`default_nettype wire

@@ hdl/cbc_ram.sv @@
// Generic single-port-write, single-port-read synchronous RAM with a registered read.
// Stands alone; no package needed.
`timescale 1ns / 1ps
`default_nettype none

module cbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ hdl/cbc_decode.sv @@
// Access decoder: banking registers, clock registers and decode of one bus access.
// Depends on cbc_pkg for the configuration and result structs.
`timescale 1ns / 1ps
`default_nettype none

module cbc_decode import cbc_pkg::*; #(
	parameter int RAM_BANKS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cfg_t        cfg,
	input  wire logic        accept,
	input  wire logic        opcode,
	input  wire logic [15:0] bus_address,
	input  wire logic [7:0]  write_byte,
	output dec_t             dec,
	output logic [$clog2(RAM_BANKS*RAM_BANK_BYTES)-1:0] ext_addr
);

	localparam int AW = $clog2(RAM_BANKS * RAM_BANK_BYTES);

	logic       ram_enable_q;
	logic [4:0] low_rom_bank_q;
	logic [8:0] wide_rom_bank_q;
	logic [3:0] ram_bank_sel_q;
	logic       bank_mode_q;
	logic       clock_mapped_q;
	logic [2:0] clock_index_q;
	logic [7:0] latch_last_q;
	logic [7:0] clock_live_q [CLOCK_REGS];
	logic [7:0] clock_held_q [CLOCK_REGS];

	logic [3:0] bank_mod [16];

	// bank numbers wrap at the physical bank count
	for (genvar g = 0; g < 16; g++) begin : g_mod
		assign bank_mod[g] = 4'(g % RAM_BANKS);
	end

	logic       is_mbc1, is_mbc3, is_mbc5, mapped;
	logic       in_ram_win, clock_sel, ram_any, ram_multi;
	logic [3:0] ram_mask, ram_page;
	logic [3:0] rom_code;
	logic [8:0] rom_mask, rom_page;
	logic       idx_ok;
	logic [7:0] held_byte;

	always_comb begin
		is_mbc1    = (cfg.mapper_kind == MAP_MBC1);
		is_mbc3    = (cfg.mapper_kind == MAP_MBC3);
		is_mbc5    = (cfg.mapper_kind == MAP_MBC5);
		mapped     = (cfg.mapper_kind != MAP_ROM);
		in_ram_win = (bus_address[15:13] == 3'b101);
		clock_sel  = is_mbc3 && clock_mapped_q && cfg.clock_present;
		idx_ok     = (clock_index_q < 3'(CLOCK_REGS));
		held_byte  = idx_ok ? clock_held_q[clock_index_q] : 8'h00;

		case (cfg.ram_code)
			3'd2:    begin ram_any = 1'b1; ram_multi = 1'b0; ram_mask = 4'h0; end
			3'd3:    begin ram_any = 1'b1; ram_multi = 1'b1; ram_mask = 4'h3; end
			3'd4:    begin ram_any = 1'b1; ram_multi = 1'b1; ram_mask = 4'hF; end
			3'd5:    begin ram_any = 1'b1; ram_multi = 1'b1; ram_mask = 4'h7; end
			default: begin ram_any = 1'b0; ram_multi = 1'b0; ram_mask = 4'h0; end
		endcase

		if (is_mbc1) begin
			ram_page = (bank_mode_q && ram_multi) ?
				({2'b00, ram_bank_sel_q[1:0]} & ram_mask) : 4'h0;
		end else begin
			ram_page = ram_bank_sel_q & ram_mask;
		end
		ext_addr = AW'({bank_mod[ram_page], bus_address[RAM_OFS_W-1:0]});

		rom_code = (cfg.rom_size_code > ROM_CODE_MAX) ? ROM_CODE_MAX : cfg.rom_size_code;
		rom_mask = 9'((10'd2 << rom_code) - 10'd1);
		if (!bus_address[14]) begin
			rom_page = (is_mbc1 && bank_mode_q) ? {2'b00, ram_bank_sel_q[1:0], 5'b00000} : 9'd0;
		end else if (is_mbc1) begin
			rom_page = {2'b00, ram_bank_sel_q[1:0], low_rom_bank_q};
		end else begin
			rom_page = wide_rom_bank_q;
		end

		dec.target    = TGT_OPEN;
		dec.phys_addr = '0;
		dec.rdata     = OPEN_BUS;
		dec.ram_re    = 1'b0;
		dec.ram_we    = 1'b0;
		if (opcode) begin
			dec.rdata  = 8'h00;
			dec.ram_we = accept && mapped && in_ram_win && ram_enable_q && !clock_sel && ram_any;
		end else if (!bus_address[15]) begin
			dec.target = TGT_ROM;
			dec.rdata  = 8'h00;
			if (!mapped) begin
				dec.phys_addr = ROM_ADDR_W'(bus_address[14:0]);
			end else begin
				dec.phys_addr = {rom_page & rom_mask, bus_address[ROM_OFS_W-1:0]};
			end
		end else if (in_ram_win && mapped && ram_enable_q) begin
			if (clock_sel) begin
				if (idx_ok) begin
					dec.target = TGT_CLOCK;
					dec.rdata  = held_byte;
				end
			end else if (ram_any) begin
				dec.target = TGT_RAM;
				dec.ram_re = accept;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_enable_q    <= 1'b0;
			low_rom_bank_q  <= 5'd1;
			wide_rom_bank_q <= 9'd1;
			ram_bank_sel_q  <= 4'd0;
			bank_mode_q     <= 1'b0;
			clock_mapped_q  <= 1'b0;
			clock_index_q   <= 3'd0;
			latch_last_q    <= 8'hFF;
			for (int i = 0; i < CLOCK_REGS; i++) begin
				clock_live_q[i] <= 8'h00;
				clock_held_q[i] <= 8'h00;
			end
		end else if (accept && opcode && mapped) begin
			case (bus_address[15:13])
				3'b000: begin
					ram_enable_q <= (write_byte[3:0] == RAM_ENABLE_KEY);
				end
				3'b001: begin
					if (is_mbc1) begin
						low_rom_bank_q <= (write_byte[4:0] == 5'd0) ? 5'd1 : write_byte[4:0];
					end else if (is_mbc3) begin
						wide_rom_bank_q <= (write_byte[6:0] == 7'd0) ? 9'd1 :
							{2'b00, write_byte[6:0]};
					end else if (!bus_address[12]) begin
						wide_rom_bank_q <= {wide_rom_bank_q[8], write_byte};
					end else begin
						wide_rom_bank_q <= {write_byte[0], wide_rom_bank_q[7:0]};
					end
				end
				3'b010: begin
					if (is_mbc1) begin
						ram_bank_sel_q <= {2'b00, write_byte[1:0]};
					end else if (is_mbc5) begin
						ram_bank_sel_q <= write_byte[3:0];
					end else if (write_byte <= RAM_SEL_LAST) begin
						ram_bank_sel_q <= write_byte[3:0];
						clock_mapped_q <= 1'b0;
					end else if (write_byte >= CLOCK_SEL_BASE && write_byte <= CLOCK_SEL_LAST) begin
						clock_index_q  <= 3'(write_byte - CLOCK_SEL_BASE);
						clock_mapped_q <= 1'b1;
					end
				end
				3'b011: begin
					if (is_mbc1) begin
						bank_mode_q <= write_byte[0];
					end else if (is_mbc3) begin
						// a 0 then 1 sequence freezes the live clock into the held copy
						if (latch_last_q == 8'h00 && write_byte == 8'h01) begin
							for (int i = 0; i < CLOCK_REGS; i++) begin
								clock_held_q[i] <= clock_live_q[i];
							end
						end
						latch_last_q <= write_byte;
					end
				end
				3'b101: begin
					if (ram_enable_q && clock_sel && idx_ok) begin
						clock_live_q[clock_index_q] <= write_byte;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ hdl/cartridge_bank_controller_top.sv @@
// Top level of the cartridge bank controller: configuration, RAM clearing and result pipeline.
// Depends on cbc_pkg, cbc_decode and cbc_ram.
`timescale 1ns / 1ps
`default_nettype none

// Usage
// One cartridge bus access enters as a transaction on the slave stream: s_tuser carries the
// read/write flag and s_tdata the address and data byte. Every access, read or write, yields
// exactly one result transaction on the master stream: m_tuser says what answered (open bus,
// ROM, external RAM or clock register) and m_tdata carries the physical ROM byte address and
// the read byte.
// Banking registers are updated at the edge that accepts a write, so the very next access
// already sees them. The external RAM is one byte-wide synchronous memory; a read is issued
// at acceptance and its data is registered in the RAM while the access waits in the first
// stage, and a write issued at acceptance is visible to a read accepted in the following
// cycle, so no forwarding is needed. m_tvalid rises when the access moves from the first
// stage into the output register, and while the receiver does not stall one access can be
// accepted in every cycle. The rate is set by the single RAM read port, used once per access.
// After reset the block sweeps the whole external RAM to zero, one byte a cycle;
// s_tready stays low meanwhile, while configuration writes are still taken.
// Configuration registers reset to zero.
// When the receiver stalls, the output register holds its result and one more access can be
// accepted into the first stage; after that s_tready drops until the output is taken.

module cartridge_bank_controller_top import cbc_pkg::*; #(
	parameter int RAM_BANKS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write port
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [3:0]  cfg_data,
	// access stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // [15:0] bus_address, [23:16] write_byte
	input  wire logic        s_tuser,   // [0] opcode
	// result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [22:0] rom_byte_address, [30:23] read_byte, [31] zero
	output logic [1:0]       m_tuser    // [1:0] target
);

	localparam int DEPTH = RAM_BANKS * RAM_BANK_BYTES;
	localparam int AW    = $clog2(DEPTH);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAPPER:   cfg_q.mapper_kind   <= cfg_data[1:0];
				REG_CLOCK:    cfg_q.clock_present <= cfg_data[0];
				REG_ROM_SIZE: cfg_q.rom_size_code <= cfg_data;
				REG_RAM_SIZE: cfg_q.ram_code      <= cfg_data[2:0];
				default: begin
				end
			endcase
		end
	end

	// Clearing sweep after reset.
	logic          clr_active_q;
	logic [AW-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
		end else if (clr_active_q) begin
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clr_active_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + AW'(1);
		end
	end

	// Handshake: the first stage may advance when the output register is free or being taken.
	logic v_s1, out_v_q, s1_free, accept;

	assign s1_free  = !out_v_q || m_tready;
	assign s_tready = !clr_active_q && (!v_s1 || s1_free);
	assign accept   = s_tvalid && s_tready;

	dec_t          dec;
	logic [AW-1:0] ext_addr;
	logic [7:0]    ram_rdata;

	cbc_decode #(
		.RAM_BANKS(RAM_BANKS)
	) u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.accept     (accept),
		.opcode     (s_tuser),
		.bus_address(s_tdata[15:0]),
		.write_byte (s_tdata[23:16]),
		.dec        (dec),
		.ext_addr   (ext_addr)
	);

	cbc_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (clr_active_q || dec.ram_we),
		.waddr(clr_active_q ? clr_addr_q : ext_addr),
		.wdata(clr_active_q ? 8'h00 : s_tdata[23:16]),
		.re   (dec.ram_re),
		.raddr(ext_addr),
		.rdata(ram_rdata)
	);

	// First stage: waits for the RAM read data. The RAM output holds until the next
	// read, which can only be issued at the edge where this stage moves on.
	logic [1:0]            tgt_s1;
	logic [ROM_ADDR_W-1:0] phys_addr_s1;
	logic [7:0]            data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (s1_free) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tgt_s1       <= dec.target;
			phys_addr_s1 <= dec.phys_addr;
			data_s1      <= dec.rdata;
		end
	end

	// Output register.
	logic [1:0]            tgt_q;
	logic [ROM_ADDR_W-1:0] phys_addr_q;
	logic [7:0]            data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (v_s1 && s1_free) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && s1_free) begin
			tgt_q       <= tgt_s1;
			phys_addr_q <= phys_addr_s1;
			data_q      <= (tgt_s1 == TGT_RAM) ? ram_rdata : data_s1;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = tgt_q;
	assign m_tdata  = {1'b0, data_q, phys_addr_q};

endmodule

`default_nettype wire
